// ===== rtl/tequ_pkg.sv =====
// ----------------------------------------------------------------------------
// tequ_pkg: shared types and constants of the timer expiry queue
// Operation codes, cell commands and the controller state encoding.
// ----------------------------------------------------------------------------
package tequ_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned IdW   = 4;
  localparam int unsigned WordW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_SCHEDULE = 2'd0,
    MODE_CANCEL   = 2'd1,
    MODE_POP      = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_MARK   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_POP    = 3'd3,
    OP_INSERT = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [IdW-1:0]   id;
  } cell_cmd_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MARK   = 6'b000010,
    S_REMOVE = 6'b000100,
    S_INSERT = 6'b001000,
    S_HEAD   = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

endpackage

// ===== rtl/tequ_if.sv =====
// ----------------------------------------------------------------------------
// tequ_if: request and response channels of the timer expiry queue
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tequ_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  timer_id;
  logic [31:0] timeout;
  logic [31:0] now;

  modport source (output valid, output mode, output timer_id, output timeout,
                  output now, input ready);
  modport sink   (input valid, input mode, input timer_id, input timeout,
                  input now, output ready);
endinterface

interface tequ_rsp_if;
  logic        valid;
  logic        ready;
  logic        has_timer;
  logic [3:0]  popped_id;
  logic [31:0] wait_time;
  logic        queue_empty;

  modport source (output valid, output has_timer, output popped_id,
                  output wait_time, output queue_empty, input ready);
  modport sink   (input valid, input has_timer, input popped_id,
                  input wait_time, input queue_empty, output ready);
endinterface

// ===== rtl/tequ_cell.sv =====
// ----------------------------------------------------------------------------
// tequ_cell: one slot of the sorted timer chain
// Holds one entry, compares it against the broadcast key and trades data
// with its left and right neighbors on remove, pop and insert.
// ----------------------------------------------------------------------------
module tequ_cell #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tequ_pkg::cell_cmd_t         cmd_i,
  input  logic [TIME_BITS-1:0]        key_exp_i,
  input  logic                        left_valid_i,
  input  logic [TIME_BITS-1:0]        left_exp_i,
  input  logic [tequ_pkg::IdW-1:0]    left_id_i,
  input  logic                        left_gt_i,
  input  logic                        left_del_i,
  input  logic                        right_valid_i,
  input  logic [TIME_BITS-1:0]        right_exp_i,
  input  logic [tequ_pkg::IdW-1:0]    right_id_i,
  output logic                        valid_o,
  output logic [TIME_BITS-1:0]        exp_o,
  output logic [tequ_pkg::IdW-1:0]    id_o,
  output logic                        gt_o,
  output logic                        del_o
);

  logic                     valid_q, valid_d;
  logic                     del_q, del_d;
  logic [TIME_BITS-1:0]     exp_q, exp_d;
  logic [tequ_pkg::IdW-1:0] id_q, id_d;

  assign gt_o    = !valid_q || (exp_q > key_exp_i);
  assign valid_o = valid_q;
  assign exp_o   = exp_q;
  assign id_o    = id_q;
  assign del_o   = del_q;

  always_comb begin
    valid_d = valid_q;
    exp_d   = exp_q;
    id_d    = id_q;
    del_d   = del_q;
    case (cmd_i.op)
      tequ_pkg::OP_MARK: begin
        del_d = del_q || left_del_i || (valid_q && (id_q == cmd_i.id));
      end
      tequ_pkg::OP_REMOVE: begin
        if (del_q) begin
          valid_d = right_valid_i;
          exp_d   = right_exp_i;
          id_d    = right_id_i;
        end
        del_d = 1'b0;
      end
      tequ_pkg::OP_POP: begin
        valid_d = right_valid_i;
        exp_d   = right_exp_i;
        id_d    = right_id_i;
      end
      tequ_pkg::OP_INSERT: begin
        if (gt_o) begin
          if (left_gt_i) begin
            valid_d = left_valid_i;
            exp_d   = left_exp_i;
            id_d    = left_id_i;
          end else begin
            valid_d = 1'b1;
            exp_d   = key_exp_i;
            id_d    = cmd_i.id;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      del_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      del_q   <= del_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    id_q  <= id_d;
  end

endmodule

// ===== rtl/timer_expiry_queue_unit.sv =====
// ----------------------------------------------------------------------------
// timer_expiry_queue_unit: pending timers sorted by absolute expiry
// A chain of TIMERS cells keeps the entries packed and earliest first.
//
//   channel  dir  word contents
//   req_i    in   mode, timer_id, timeout, now
//   rsp_o    out  has_timer, popped_id, wait_time, queue_empty
//
// Schedule steps through mark, remove, insert and response; cancel skips
// insert; pop and query go through head and response. The cancel mark
// ripples one cell per cycle down the chain. One word is in work at a time.
// The response register holds its word while rsp_o.ready is low; the next
// request is still taken and waits to load it. Reset empties the queue.
// ----------------------------------------------------------------------------
module timer_expiry_queue_unit #(
  parameter int unsigned TIMERS    = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tequ_req_if.sink    req_i,
  tequ_rsp_if.source  rsp_o
);

  localparam int unsigned CntW = $clog2(TIMERS);

  tequ_pkg::state_e          state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  tequ_pkg::mode_e           mode_q;
  logic [tequ_pkg::IdW-1:0]  tid_q;
  logic [TIME_BITS-1:0]      now_q;
  logic [TIME_BITS-1:0]      key_q;

  logic                       res_has_q, res_has_d;
  logic [tequ_pkg::IdW-1:0]   res_pid_q, res_pid_d;
  logic [tequ_pkg::WordW-1:0] res_wait_q, res_wait_d;

  logic                       rsp_valid_q;
  logic                       rsp_has_q;
  logic [tequ_pkg::IdW-1:0]   rsp_pid_q;
  logic [tequ_pkg::WordW-1:0] rsp_wait_q;
  logic                       rsp_empty_q;

  logic [TIME_BITS-1:0] now_t, tmo_t, exp_sat, diff;
  logic [TIME_BITS:0]   sum;
  logic [63:0]          diff_w;
  logic                 accept, load_rsp;

  tequ_pkg::cell_cmd_t        cmd;
  logic [TIMERS-1:0]          v_vec, gt_vec, del_vec;
  logic [TIME_BITS-1:0]       e_arr [TIMERS];
  logic [tequ_pkg::IdW-1:0]   id_arr [TIMERS];

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == tequ_pkg::S_IDLE);

  assign now_t   = TIME_BITS'(64'(req_i.now));
  assign tmo_t   = TIME_BITS'(64'(req_i.timeout));
  assign sum     = {1'b0, now_t} + {1'b0, tmo_t};
  assign exp_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  assign diff   = (e_arr[0] > now_q) ? (e_arr[0] - now_q) : '0;
  assign diff_w = 64'(diff);

  assign load_rsp = (state_q == tequ_pkg::S_RESP) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    res_has_d  = res_has_q;
    res_pid_d  = res_pid_q;
    res_wait_d = res_wait_q;
    cmd.op     = tequ_pkg::OP_HOLD;
    cmd.id     = tid_q;
    case (state_q)
      tequ_pkg::S_IDLE: begin
        if (accept) begin
          res_has_d  = 1'b0;
          res_pid_d  = '0;
          res_wait_d = '0;
          cnt_d      = '0;
          if (req_i.mode == tequ_pkg::MODE_SCHEDULE || req_i.mode == tequ_pkg::MODE_CANCEL) begin
            state_d = tequ_pkg::S_MARK;
          end else begin
            state_d = tequ_pkg::S_HEAD;
          end
        end
      end
      tequ_pkg::S_MARK: begin
        cmd.op = tequ_pkg::OP_MARK;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(TIMERS - 1)) begin
          state_d = tequ_pkg::S_REMOVE;
        end
      end
      tequ_pkg::S_REMOVE: begin
        cmd.op  = tequ_pkg::OP_REMOVE;
        state_d = (mode_q == tequ_pkg::MODE_SCHEDULE) ? tequ_pkg::S_INSERT : tequ_pkg::S_RESP;
      end
      tequ_pkg::S_INSERT: begin
        if (!v_vec[TIMERS-1]) begin
          cmd.op = tequ_pkg::OP_INSERT;
        end
        state_d = tequ_pkg::S_RESP;
      end
      tequ_pkg::S_HEAD: begin
        if (v_vec[0]) begin
          res_has_d = 1'b1;
          if (mode_q == tequ_pkg::MODE_POP) begin
            cmd.op    = tequ_pkg::OP_POP;
            res_pid_d = id_arr[0];
          end else begin
            res_wait_d = (|diff_w[63:32]) ? {tequ_pkg::WordW{1'b1}} : diff_w[31:0];
          end
        end
        state_d = tequ_pkg::S_RESP;
      end
      tequ_pkg::S_RESP: begin
        if (load_rsp) begin
          state_d = tequ_pkg::S_IDLE;
        end
      end
      default: state_d = tequ_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tequ_pkg::S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_has_q  <= res_has_d;
    res_pid_q  <= res_pid_d;
    res_wait_q <= res_wait_d;
    if (accept) begin
      mode_q <= tequ_pkg::mode_e'(req_i.mode);
      tid_q  <= req_i.timer_id;
      now_q  <= now_t;
      key_q  <= exp_sat;
    end
    if (load_rsp) begin
      rsp_has_q   <= res_has_q;
      rsp_pid_q   <= res_pid_q;
      rsp_wait_q  <= res_wait_q;
      rsp_empty_q <= !v_vec[0];
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.has_timer   = rsp_has_q;
  assign rsp_o.popped_id   = rsp_pid_q;
  assign rsp_o.wait_time   = rsp_wait_q;
  assign rsp_o.queue_empty = rsp_empty_q;

  for (genvar k = 0; k < TIMERS; k++) begin : g_cell
    logic                     lv, lg, ld, rv;
    logic [TIME_BITS-1:0]     le, re;
    logic [tequ_pkg::IdW-1:0] li, ri;

    if (k == 0) begin : g_head
      assign lv = 1'b0;
      assign le = '0;
      assign li = '0;
      assign lg = 1'b0;
      assign ld = 1'b0;
    end else begin : g_body
      assign lv = v_vec[k-1];
      assign le = e_arr[k-1];
      assign li = id_arr[k-1];
      assign lg = gt_vec[k-1];
      assign ld = del_vec[k-1];
    end

    if (k == TIMERS - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
      assign ri = '0;
    end else begin : g_inner
      assign rv = v_vec[k+1];
      assign re = e_arr[k+1];
      assign ri = id_arr[k+1];
    end

    tequ_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .key_exp_i     (key_q),
      .left_valid_i  (lv),
      .left_exp_i    (le),
      .left_id_i     (li),
      .left_gt_i     (lg),
      .left_del_i    (ld),
      .right_valid_i (rv),
      .right_exp_i   (re),
      .right_id_i    (ri),
      .valid_o       (v_vec[k]),
      .exp_o         (e_arr[k]),
      .id_o          (id_arr[k]),
      .gt_o          (gt_vec[k]),
      .del_o         (del_vec[k])
    );
  end

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_vec & (v_vec + 1'b1)) == '0)
    else $error("valid cells do not form a prefix");

  a_marks_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tequ_pkg::S_REMOVE) |=> (del_vec == '0))
    else $error("remove marks left behind");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while busy");

endmodule
